FILE: rtl/lkia_pkg.sv
package lkia_pkg;

  // Number of entries in the recency chain; also the largest id handed out.
  localparam int unsigned Capacity = 64;
  // Key bits that take part in the compare.
  localparam int unsigned KeyBits  = 64;
  // Fixed widths of the ports.
  localparam int unsigned TagW     = 64;
  localparam int unsigned IdW      = 7;
  // Fresh-id counter must hold Capacity itself.
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  typedef logic [KeyBits-1:0] key_t;
  typedef logic [IdW-1:0]     id_t;
  typedef logic [CntW-1:0]    cnt_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic cmp;    // latch match against the incoming key
    logic shift;  // take the neighbor's entry
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } state_e;

endpackage

FILE: rtl/lkia_cell.sv
module lkia_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lkia_pkg::cell_ctl_t ctl_i,
  input  lkia_pkg::key_t     lookup_key_i,
  input  lkia_pkg::key_t     prev_key_i,
  input  lkia_pkg::id_t      prev_id_i,
  input  logic               prev_valid_i,
  output lkia_pkg::key_t     key_o,
  output lkia_pkg::id_t      id_o,
  output logic               valid_o,
  output logic               match_o
);

  lkia_pkg::key_t key_q;
  lkia_pkg::id_t  id_q;
  logic           valid_q;
  logic           match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.shift) begin
      valid_q <= prev_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      key_q <= prev_key_i;
      id_q  <= prev_id_i;
    end
    if (ctl_i.cmp) begin
      match_q <= valid_q && (key_q == lookup_key_i);
    end
  end

  assign key_o   = key_q;
  assign id_o    = id_q;
  assign valid_o = valid_q;
  assign match_o = match_q;

endmodule

FILE: rtl/lru_key_to_id_allocator.sv
// Channel  | Ports                                       | Handshake
// request  | has_properties_i, key_tag_i                 | start_i & !busy_o
// result   | has_schema_o, schema_id_o, is_new_o         | done_o, one cycle
//
// For each request, the accept edge compares the key in every cell of the
// recency chain at once; in the ST_UPD state that follows, the chain shifts
// and the result is registered at its end. busy_o is high in ST_UPD only.
// done_o follows in the cycle after busy_o and may overlap the next accept.
// Reset empties the chain (valid bits clear) and zeroes the id counter;
// no clearing pass. The receiver cannot stall; results are never held.
module lru_key_to_id_allocator (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  has_properties_i,
  input  logic [lkia_pkg::TagW-1:0] key_tag_i,
  output logic                  done_o,
  output logic                  has_schema_o,
  output logic [lkia_pkg::IdW-1:0] schema_id_o,
  output logic                  is_new_o
);

  localparam int unsigned N = lkia_pkg::Capacity;

  lkia_pkg::state_e state_q, state_d;
  logic             has_q;
  lkia_pkg::key_t   key_q;
  lkia_pkg::cnt_t   cnt_q, cnt_d;
  logic             done_q;
  logic             has_schema_q;
  lkia_pkg::id_t    schema_id_q;
  logic             is_new_q;

  logic           accept;
  logic           upd;
  logic           hit;
  logic           miss;
  lkia_pkg::id_t  hit_id;
  lkia_pkg::id_t  head_id;

  logic [N-1:0]               match_vec;
  logic [N-1:0]               suffix_hit;
  lkia_pkg::cell_ctl_t        ctl [N];
  lkia_pkg::key_t             cell_key [N];
  lkia_pkg::id_t              cell_id [N];
  logic [N-1:0]               cell_valid;

  assign accept = start_i && (state_q == lkia_pkg::ST_IDLE);
  assign upd    = (state_q == lkia_pkg::ST_UPD);
  assign busy_o = upd;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lkia_pkg::ST_IDLE: if (start_i) state_d = lkia_pkg::ST_UPD;
      lkia_pkg::ST_UPD:  state_d = lkia_pkg::ST_IDLE;
      default:           state_d = lkia_pkg::ST_IDLE;
    endcase
  end

  assign hit  = |match_vec;
  assign miss = upd && has_q && !hit;

  // Matched cell's id: one-hot AND-OR.
  always_comb begin
    hit_id = '0;
    for (int i = 0; i < N; i++) begin
      hit_id = hit_id | (match_vec[i] ? cell_id[i] : '0);
    end
  end

  // Matched id on a hit; else a fresh id while any remain, else recycle the tail (least recent) entry.
  always_comb begin
    priority if (hit) begin
      head_id = hit_id;
    end else if (cnt_q < lkia_pkg::cnt_t'(N)) begin
      head_id = lkia_pkg::IdW'(cnt_q + lkia_pkg::cnt_t'(1));
    end else begin
      head_id = cell_id[N-1];
    end
  end

  assign cnt_d = (miss && (cnt_q < lkia_pkg::cnt_t'(N))) ?
                 lkia_pkg::cnt_t'(cnt_q + lkia_pkg::cnt_t'(1)) : cnt_q;

  for (genvar i = 0; i < N; i++) begin : g_chain
    // Cells up to the hit move one step toward the tail; a miss moves all.
    assign suffix_hit[i] = |match_vec[N-1:i];
    assign ctl[i].cmp    = accept;
    assign ctl[i].shift  = upd && has_q && (suffix_hit[i] || !hit);

    if (i == 0) begin : g_head
      lkia_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctl_i        (ctl[i]),
        .lookup_key_i (key_tag_i[lkia_pkg::KeyBits-1:0]),
        .prev_key_i   (key_q),
        .prev_id_i    (head_id),
        .prev_valid_i (1'b1),
        .key_o        (cell_key[i]),
        .id_o         (cell_id[i]),
        .valid_o      (cell_valid[i]),
        .match_o      (match_vec[i])
      );
    end else begin : g_body
      lkia_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctl_i        (ctl[i]),
        .lookup_key_i (key_tag_i[lkia_pkg::KeyBits-1:0]),
        .prev_key_i   (cell_key[i-1]),
        .prev_id_i    (cell_id[i-1]),
        .prev_valid_i (cell_valid[i-1]),
        .key_o        (cell_key[i]),
        .id_o         (cell_id[i]),
        .valid_o      (cell_valid[i]),
        .match_o      (match_vec[i])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkia_pkg::ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= upd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      has_q <= has_properties_i;
      key_q <= key_tag_i[lkia_pkg::KeyBits-1:0];
    end
    if (upd) begin
      has_schema_q <= has_q;
      schema_id_q  <= has_q ? head_id : '0;
      is_new_q     <= has_q && !hit;
    end
  end

  assign done_o       = done_q;
  assign has_schema_o = has_schema_q;
  assign schema_id_o  = schema_id_q;
  assign is_new_o     = is_new_q;

  // Keys in the chain are unique, so at most one cell can match.
  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd |-> $onehot0(match_vec))
    else $error("more than one cell matched the key");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= lkia_pkg::cnt_t'(N))
    else $error("fresh-id counter beyond capacity");

  a_done_after_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd |=> done_o && !busy_o)
    else $error("result not delivered after update");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !has_schema_o) |-> (schema_id_o == '0) && !is_new_o)
    else $error("empty request returned an id");

  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (cell_valid[0] == (cnt_q != '0)))
    else $error("head cell validity disagrees with counter");

endmodule
